>>> design/text_console_cursor_macros.svh
// assertion helpers for the text console cursor
`ifndef TEXT_CONSOLE_CURSOR_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define TCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tcc_pkg.sv
package tcc_pkg;

	// fixed field widths of the ports
	localparam int CHAR_W = 8;
	localparam int ROW_FW = 6;
	localparam int COL_FW = 7;
	// staging width for resizing cursor values to field widths
	localparam int EXT_W  = 9;

	// default grid size
	localparam int ROWS_DEF = 48;
	localparam int COLS_DEF = 128;

	// control codes
	localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CODE_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

endpackage

>>> design/text_console_cursor.sv
// Cursor control for a text console of ROWS x COLS cells. Each request carries one character
// byte; each yields one result with an optional cell write (position and byte) and the cursor
// position after the character. Backspace steps back and blanks that cell (no effect at the
// origin), newline goes to column 0 of the next row, carriage return homes the cursor, tab is
// ignored, and any other byte is written at the cursor, which then advances and wraps. Running
// past the last cell raises scroll_req and leaves the cursor at column 0 of the last row; a byte
// written into the last cell comes in the same result as that scroll. The block takes one
// character every cycle unless a stalled result backs up into the input register: an
// input register feeds a single pass of compare and increment logic against the cursor
// registers, whose result lands in the output register together with the cursor update.
// Row and column outputs keep only their low 6 and 7 bits when the grid is larger.
`include "text_console_cursor_macros.svh"

module text_console_cursor
	import tcc_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] char_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              write_en,
	output logic [ROW_FW-1:0] write_row,
	output logic [COL_FW-1:0] write_col,
	output logic [CHAR_W-1:0] write_char,
	output logic              scroll_req,
	output logic [ROW_FW-1:0] cur_row,
	output logic [COL_FW-1:0] cur_col
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam logic [RW:0]   ROWS_X    = (RW+1)'(ROWS);
	localparam logic [CW:0]   COLS_X    = (CW+1)'(COLS);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

	// pipeline and cursor registers
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              valid_s2;
	logic              wen_s2;
	logic [ROW_FW-1:0] wrow_s2;
	logic [COL_FW-1:0] wcol_s2;
	logic [CHAR_W-1:0] wchar_s2;
	logic              scroll_s2;
	logic [ROW_FW-1:0] crow_s2;
	logic [COL_FW-1:0] ccol_s2;
	logic [RW-1:0]     cursor_row_q;
	logic [CW-1:0]     cursor_col_q;

	// flow control
	logic s2_open;
	logic s1_open;
	logic advance;

	// single pass results
	logic              wen_d;
	logic [RW-1:0]     wrow_d;
	logic [CW-1:0]     wcol_d;
	logic [CHAR_W-1:0] wchar_d;
	logic [RW:0]       row_x;
	logic [CW:0]       col_inc;
	logic [CW-1:0]     col_d;
	logic              scroll_d;
	logic [RW-1:0]     row_d;
	logic [CW-1:0]     ncol_d;
	logic [EXT_W-1:0]  wrow_ext;
	logic [EXT_W-1:0]  wcol_ext;
	logic [EXT_W-1:0]  row_ext;
	logic [EXT_W-1:0]  col_ext;

	// handshake: stage 2 frees up when its result is taken
	assign s2_open  = !valid_s2 || !out_stall;
	assign s1_open  = !valid_s1 || s2_open;
	assign advance  = valid_s1 && s2_open;
	assign in_stall = !s1_open;

	// character decode against the current cursor
	always_comb begin
		wen_d   = 1'b0;
		wrow_d  = '0;
		wcol_d  = '0;
		wchar_d = '0;
		row_x   = {1'b0, cursor_row_q};
		col_d   = cursor_col_q;
		col_inc = {1'b0, cursor_col_q} + (CW+1)'(1);
		case (char_s1)
			CODE_BS: begin
				if (cursor_row_q != '0 || cursor_col_q != '0) begin
					if (cursor_col_q == '0) begin
						row_x = {1'b0, cursor_row_q} - (RW+1)'(1);
						col_d = LAST_COL;
					end else begin
						col_d = cursor_col_q - CW'(1);
					end
					wen_d   = 1'b1;
					wrow_d  = row_x[RW-1:0];
					wcol_d  = col_d;
					wchar_d = CODE_SPACE;
				end
			end
			CODE_NL: begin
				col_d = '0;
				row_x = {1'b0, cursor_row_q} + (RW+1)'(1);
			end
			CODE_CR: begin
				col_d = '0;
				row_x = '0;
			end
			CODE_TAB: begin
				col_d = cursor_col_q;
			end
			default: begin
				wen_d   = 1'b1;
				wrow_d  = cursor_row_q;
				wcol_d  = cursor_col_q;
				wchar_d = char_s1;
				if (col_inc >= COLS_X) begin
					col_d = '0;
					row_x = {1'b0, cursor_row_q} + (RW+1)'(1);
				end else begin
					col_d = col_inc[CW-1:0];
				end
			end
		endcase

		// past the last row: scroll and park at the start of the last row
		scroll_d = (row_x >= ROWS_X);
		row_d    = scroll_d ? LAST_ROW : row_x[RW-1:0];
		ncol_d   = scroll_d ? '0 : col_d;

		// resize to field widths
		wrow_ext = EXT_W'(wrow_d);
		wcol_ext = EXT_W'(wcol_d);
		row_ext  = EXT_W'(row_d);
		col_ext  = EXT_W'(ncol_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
		end else begin
			if (s1_open) begin
				valid_s1 <= in_valid;
			end
			if (s2_open) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				cursor_row_q <= row_d;
				cursor_col_q <= ncol_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s1_open && in_valid) begin
			char_s1 <= char_code;
		end
		if (advance) begin
			wen_s2    <= wen_d;
			wrow_s2   <= wrow_ext[ROW_FW-1:0];
			wcol_s2   <= wcol_ext[COL_FW-1:0];
			wchar_s2  <= wchar_d;
			scroll_s2 <= scroll_d;
			crow_s2   <= row_ext[ROW_FW-1:0];
			ccol_s2   <= col_ext[COL_FW-1:0];
		end
	end

	// result port
	assign out_valid  = valid_s2;
	assign write_en   = wen_s2;
	assign write_row  = wrow_s2;
	assign write_col  = wcol_s2;
	assign write_char = wchar_s2;
	assign scroll_req = scroll_s2;
	assign cur_row    = crow_s2;
	assign cur_col    = ccol_s2;

	// checks
	`TCC_ASSERT_IMP(a_cursor_in_grid, clk, arst_n, 1'b1,
		(int'(cursor_row_q) < ROWS) && (int'(cursor_col_q) < COLS), "cursor left the grid")
	`TCC_ASSERT_IMP(a_scroll_parks, clk, arst_n, advance && scroll_d,
		(row_d == LAST_ROW) && (ncol_d == '0), "scroll without parking on last row")
	`TCC_ASSERT_IMP(a_idle_write_clear, clk, arst_n, valid_s2 && !wen_s2,
		(wrow_s2 == '0) && (wcol_s2 == '0) && (wchar_s2 == '0), "write fields set without write")
	`TCC_ASSERT_NEXT(a_stall_holds_cursor, clk, arst_n, valid_s2 && out_stall,
		$stable(cursor_row_q) && $stable(cursor_col_q), "cursor moved while result stalled")

endmodule
